// ===== rtl/esds_pkg.sv =====
// Shared types and constants for the ESDS decoder-specific-info extractor.
// No dependencies; imported by esds_parse and esds_specific_info_extractor.
package esds_pkg;

    // Longest length field of a descriptor header, in bytes
    localparam int ESDS_MAX_LEN_BYTES = 4;

    // Parser phases
    localparam logic [3:0] PH_TAG1  = 4'd0;
    localparam logic [3:0] PH_LEN1  = 4'd1;
    localparam logic [3:0] PH_SKIP1 = 4'd2;
    localparam logic [3:0] PH_TAG2  = 4'd3;
    localparam logic [3:0] PH_LEN2  = 4'd4;
    localparam logic [3:0] PH_SKIP2 = 4'd5;
    localparam logic [3:0] PH_TAG3  = 4'd6;
    localparam logic [3:0] PH_LEN3  = 4'd7;
    localparam logic [3:0] PH_PAY   = 4'd8;

    // Descriptor tags
    localparam logic [7:0] TAG_ES_DESC   = 8'h03;
    localparam logic [7:0] TAG_DEC_CFG   = 8'h04;
    localparam logic [7:0] TAG_DEC_SPEC  = 8'h05;

    // Bytes skipped after the headers
    localparam logic [3:0] SKIP_ES_FULL  = 4'd3;
    localparam logic [3:0] SKIP_ES_SHORT = 4'd2;
    localparam logic [3:0] SKIP_DEC_CFG  = 4'd13;

    // One parser result, plus a flag that says whether a transaction is produced
    typedef struct packed {
        logic       emit;
        logic       has_byte;
        logic [7:0] payload_byte;
        logic       done_res;
        logic       status;
    } t_result;

endpackage

// ===== rtl/esds_parse.sv =====
// Descriptor parser state and its one-step update logic.
// Depends on esds_pkg (phase codes, tags, t_result).
module esds_parse #(
    parameter int MAX_LENGTH_BYTES = esds_pkg::ESDS_MAX_LEN_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,     // process i_byte/i_last this cycle
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output esds_pkg::t_result o_res
);
    import esds_pkg::*;

    localparam int LEN_W  = 7 * MAX_LENGTH_BYTES;
    localparam int SEEN_W = $clog2(MAX_LENGTH_BYTES + 1);

    logic [3:0]        r_phase,    n_phase;
    logic              r_tag_es,   n_tag_es;     // first tag was 0x03
    logic [LEN_W-1:0]  r_len_acc,  n_len_acc;
    logic [SEEN_W-1:0] r_seen,     n_seen;
    logic [3:0]        r_skip,     n_skip;
    logic [LEN_W-1:0]  r_pay_left, n_pay_left;
    logic              r_finished, n_finished;

    logic [LEN_W+6:0]  acc_wide;
    logic [LEN_W-1:0]  acc_next;
    logic [SEEN_W-1:0] seen_inc;
    logic              len_done;
    logic              has, done, err;

    assign acc_wide = {r_len_acc, i_byte[6:0]};
    assign acc_next = acc_wide[LEN_W-1:0];
    assign seen_inc = r_seen + SEEN_W'(1);
    // Header ends on a clear continuation bit or at the byte limit
    assign len_done = !i_byte[7] || (seen_inc == SEEN_W'(MAX_LENGTH_BYTES));

    always_comb begin
        n_phase    = r_phase;
        n_tag_es   = r_tag_es;
        n_len_acc  = r_len_acc;
        n_seen     = r_seen;
        n_skip     = r_skip;
        n_pay_left = r_pay_left;
        n_finished = r_finished;
        has        = 1'b0;
        done       = 1'b0;
        err        = 1'b0;

        if (!r_finished) begin
            unique case (r_phase)
                PH_TAG1: begin
                    n_tag_es  = (i_byte == TAG_ES_DESC);
                    n_len_acc = '0;
                    n_seen    = '0;
                    n_phase   = PH_LEN1;
                end
                PH_LEN1: begin
                    n_len_acc = acc_next;
                    n_seen    = seen_inc;
                    if (len_done) begin
                        n_skip  = r_tag_es ? SKIP_ES_FULL : SKIP_ES_SHORT;
                        n_phase = PH_SKIP1;
                    end
                end
                PH_SKIP1: begin
                    n_skip = r_skip - 4'd1;
                    if (r_skip == 4'd1) begin
                        n_phase = PH_TAG2;
                    end
                end
                PH_TAG2: begin
                    if (i_byte != TAG_DEC_CFG) begin
                        done = 1'b1;
                        err  = 1'b1;
                    end else begin
                        n_len_acc = '0;
                        n_seen    = '0;
                        n_phase   = PH_LEN2;
                    end
                end
                PH_LEN2: begin
                    n_len_acc = acc_next;
                    n_seen    = seen_inc;
                    if (len_done) begin
                        n_skip  = SKIP_DEC_CFG;
                        n_phase = PH_SKIP2;
                    end
                end
                PH_SKIP2: begin
                    n_skip = r_skip - 4'd1;
                    if (r_skip == 4'd1) begin
                        n_phase = PH_TAG3;
                    end
                end
                PH_TAG3: begin
                    if (i_byte != TAG_DEC_SPEC) begin
                        done = 1'b1;
                        err  = 1'b1;
                    end else begin
                        n_len_acc = '0;
                        n_seen    = '0;
                        n_phase   = PH_LEN3;
                    end
                end
                PH_LEN3: begin
                    n_len_acc = acc_next;
                    n_seen    = seen_inc;
                    if (len_done) begin
                        n_pay_left = acc_next;
                        if (acc_next == '0) begin
                            done = 1'b1;   // empty payload
                        end else begin
                            n_phase = PH_PAY;
                        end
                    end
                end
                PH_PAY: begin
                    has        = 1'b1;
                    n_pay_left = r_pay_left - LEN_W'(1);
                    if (r_pay_left == LEN_W'(1)) begin
                        done = 1'b1;
                    end
                end
                default: begin
                    done = 1'b1;
                    err  = 1'b1;
                end
            endcase

            // Blob ended before the run completed
            if (!done && i_last) begin
                done = 1'b1;
                err  = 1'b1;
            end
            if (done) begin
                n_finished = 1'b1;
            end
        end

        // Last byte of a blob rearms the parser
        if (i_last) begin
            n_phase    = PH_TAG1;
            n_tag_es   = 1'b0;
            n_len_acc  = '0;
            n_seen     = '0;
            n_skip     = '0;
            n_pay_left = '0;
            n_finished = 1'b0;
        end
    end

    always_comb begin
        o_res.emit         = has || done;
        o_res.has_byte     = has;
        o_res.payload_byte = has ? i_byte : 8'd0;
        o_res.done_res     = done;
        o_res.status       = done && err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_TAG1;
            r_tag_es   <= 1'b0;
            r_len_acc  <= '0;
            r_seen     <= '0;
            r_skip     <= '0;
            r_pay_left <= '0;
            r_finished <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_tag_es   <= n_tag_es;
            r_len_acc  <= n_len_acc;
            r_seen     <= n_seen;
            r_skip     <= n_skip;
            r_pay_left <= n_pay_left;
            r_finished <= n_finished;
        end
    end

endmodule

// ===== rtl/esds_specific_info_extractor.sv =====
// Top level: input register, descriptor parser and output register.
// Depends on esds_pkg and esds_parse.
//
//  channel   | dir | tdata               | tuser                       | tlast
//  ----------+-----+---------------------+-----------------------------+---------
//  s (bytes) | in  | [7:0] in_byte       | -                           | in_last
//  m (result)| out | [7:0] payload_byte  | [0] has_byte, [1] status    | done_res
//
// One byte per cycle sustained while the master side accepts. A byte is registered on
// acceptance and parsed from the input register once the output register is free;
// its result (if any) is loaded into the output register at the end of that cycle.
// Most bytes (headers, skipped bytes, bytes after the status) produce no transaction.
// Reset is synchronous, active low, and returns the parser to waiting for the first tag.
// A stalled master side holds the output register; the pipeline then advances only when
// that register is empty or being taken.
module esds_specific_info_extractor #(
    parameter int MAX_LENGTH_BYTES = esds_pkg::ESDS_MAX_LEN_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte stream in
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,   // in_last
    // result stream out
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] payload_byte
    output logic [1:0] o_m_tuser,   // [0] has_byte, [1] status
    output logic       o_m_tlast    // done_res
);
    import esds_pkg::*;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_has;
    logic       r_out_done;
    logic       r_out_status;

    logic       pipe_en;     // output register free for a new result
    logic       step;        // parser consumes the registered byte
    t_result    res;

    assign pipe_en    = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && pipe_en;
    assign o_s_tready = pipe_en || !r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    esds_parse #(
        .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_out_valid <= step && res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.emit) begin
            r_out_byte   <= res.payload_byte;
            r_out_has    <= res.has_byte;
            r_out_done   <= res.done_res;
            r_out_status <= res.status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tuser  = {r_out_status, r_out_has};
    assign o_m_tlast  = r_out_done;

    // An error status always closes the run
    a_status_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tlast)
        else $error("error status without done_res");

    // Every transaction carries a payload byte or ends the run
    a_no_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[0] || o_m_tlast))
        else $error("result with neither byte nor done");

    // A registered byte is never dropped while the output side stalls
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !pipe_en |=> r_in_valid)
        else $error("input register lost a byte under stall");

    // No payload value without has_byte
    a_clean_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> (o_m_tdata == 8'd0))
        else $error("payload byte set without has_byte");

endmodule
